// ===== design/dhtfd_pkg.sv =====
// dhtfd_pkg: types and constants shared by the sensor frame decoder modules
// no dependencies
`default_nettype none

package dhtfd_pkg;

    // frame layout
    localparam int DATA_BITS  = 40;
    localparam int COUNT_W    = 6;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;

    // edge counter saturates here
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // item kinds
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_EOF  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd2;

    // configuration register map
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic REG_BIT_THRESHOLD = 1'b0;
    localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 8'd90;

    typedef struct packed {
        logic [BYTE_W-1:0]   humidity;
        logic [BYTE_W-1:0]   temp_whole;
        logic [BYTE_W-1:0]   temp_frac;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

// ===== design/dht_frame_decoder.sv =====
// dht_frame_decoder: top level of the single-wire sensor frame decoder
// depends on dhtfd_pkg, dhtfd_cfg, dhtfd_frame
//
// usage
//   input channel (i_in_valid / o_in_ready) carries one beat per falling edge
//   (i_func = 0, i_interval_us = us since the previous edge) or one beat per
//   idle timeout (i_func = 1). edge beats produce no result; each end-of-frame
//   beat produces exactly one result beat on o_out_valid / i_out_ready with
//   the held humidity, temperature and a status (good, checksum, short).
//   the bit threshold is set through the apb port (register 0, offset 0).
// timing
//   one beat is accepted every cycle unless an end-of-frame beat waits in the
//   input register behind a stalled result. a beat is taken into an input
//   register, the frame state is updated from that register at the edge on which
//   the beat advances, and the result lands in the output register at that edge.
// reset
//   synchronous, active low: threshold back to 90 us, edge count, bit
//   shifter and held readings cleared, both pipeline registers empty.
// stalls
//   while a result waits on i_out_ready, edge beats keep flowing; a second
//   end-of-frame beat waits in the input register and o_in_ready drops.
`default_nettype none

module dht_frame_decoder #(
    parameter int LEAD_EDGES = 2
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_func,
    input  wire logic [7:0]                          i_interval_us,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [7:0]                          o_humidity,
    output logic      [7:0]                          o_temp_whole,
    output logic      [7:0]                          o_temp_frac,
    output logic      [1:0]                          o_status,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dhtfd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [dhtfd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [dhtfd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready
);

    logic                          r_in_valid;
    logic                          r_in_func;
    logic [dhtfd_pkg::BYTE_W-1:0]  r_in_interval;
    logic                          r_out_valid;
    dhtfd_pkg::t_result            r_out;

    logic                          advance;
    logic                          in_fire;
    logic [dhtfd_pkg::BYTE_W-1:0]  threshold;
    dhtfd_pkg::t_result            frame_result;

    // edge beats never need the output slot
    assign advance = r_in_valid &&
                     ((r_in_func == dhtfd_pkg::FUNC_EDGE) || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    dhtfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold)
    );

    dhtfd_frame #(
        .LEAD_EDGES (LEAD_EDGES)
    ) u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_func        (r_in_func),
        .i_interval_us (r_in_interval),
        .i_threshold   (threshold),
        .o_result      (frame_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_func     <= i_func;
            r_in_interval <= i_interval_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && (r_in_func == dhtfd_pkg::FUNC_EOF)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && (r_in_func == dhtfd_pkg::FUNC_EOF)) begin
            r_out <= frame_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_humidity   = r_out.humidity;
    assign o_temp_whole = r_out.temp_whole;
    assign o_temp_frac  = r_out.temp_frac;
    assign o_status     = r_out.status;

endmodule

`default_nettype wire

// ===== design/dhtfd_cfg.sv =====
// dhtfd_cfg: apb register block holding the bit threshold
// depends on dhtfd_pkg
`default_nettype none

module dhtfd_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dhtfd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [dhtfd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [dhtfd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready,
    output logic      [dhtfd_pkg::BYTE_W-1:0]        o_threshold
);

    logic [dhtfd_pkg::BYTE_W-1:0] r_threshold;
    logic                         reg_hit;

    // word index sits above the byte offset
    assign reg_hit = (paddr[2] == dhtfd_pkg::REG_BIT_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= dhtfd_pkg::THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_threshold <= pwdata[dhtfd_pkg::BYTE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = {{(dhtfd_pkg::CFG_DATA_W-dhtfd_pkg::BYTE_W){1'b0}}, r_threshold};
        end
    end

    assign pready      = 1'b1;
    assign o_threshold = r_threshold;

endmodule

`default_nettype wire

// ===== design/dhtfd_frame.sv =====
// dhtfd_frame: edge counter, bit shifter, checksum check and held readings
// depends on dhtfd_pkg
`default_nettype none

module dhtfd_frame #(
    parameter int LEAD_EDGES = 2
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic                           i_func,
    input  wire logic [dhtfd_pkg::BYTE_W-1:0]   i_interval_us,
    input  wire logic [dhtfd_pkg::BYTE_W-1:0]   i_threshold,
    output dhtfd_pkg::t_result                  o_result
);

    localparam logic [dhtfd_pkg::COUNT_W-1:0] LEAD_CNT  =
        dhtfd_pkg::COUNT_W'(LEAD_EDGES);
    localparam logic [dhtfd_pkg::COUNT_W-1:0] FRAME_CNT =
        dhtfd_pkg::COUNT_W'(LEAD_EDGES + dhtfd_pkg::DATA_BITS);

    logic [dhtfd_pkg::COUNT_W-1:0]   r_edge_count;
    logic [dhtfd_pkg::DATA_BITS-1:0] r_bit_shift;
    logic [dhtfd_pkg::BYTE_W-1:0]    r_held_humidity;
    logic [dhtfd_pkg::BYTE_W-1:0]    r_held_temp_whole;
    logic [dhtfd_pkg::BYTE_W-1:0]    r_held_temp_frac;

    logic                            in_window;
    logic                            bit_val;
    logic                            frame_full;
    logic                            sum_ok;
    logic [dhtfd_pkg::BYTE_W-1:0]    b0, b1, b2, b3, b4, sum8;

    assign in_window  = (r_edge_count >= LEAD_CNT) && (r_edge_count < FRAME_CNT);
    assign bit_val    = (i_interval_us > i_threshold);
    assign frame_full = (r_edge_count >= FRAME_CNT);

    assign b0 = r_bit_shift[39:32];
    assign b1 = r_bit_shift[31:24];
    assign b2 = r_bit_shift[23:16];
    assign b3 = r_bit_shift[15:8];
    assign b4 = r_bit_shift[7:0];
    // checksum wraps at 8 bits
    assign sum8   = b0 + b1 + b2 + b3;
    assign sum_ok = (sum8 == b4);

    always_comb begin
        o_result.humidity   = r_held_humidity;
        o_result.temp_whole = r_held_temp_whole;
        o_result.temp_frac  = r_held_temp_frac;
        priority if (!frame_full) begin
            o_result.status = dhtfd_pkg::ST_SHORT;
        end else if (sum_ok) begin
            o_result.humidity   = b0;
            o_result.temp_whole = b2;
            o_result.temp_frac  = b3;
            o_result.status     = dhtfd_pkg::ST_GOOD;
        end else begin
            o_result.status = dhtfd_pkg::ST_CHECKSUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count      <= '0;
            r_bit_shift       <= '0;
            r_held_humidity   <= '0;
            r_held_temp_whole <= '0;
            r_held_temp_frac  <= '0;
        end else if (i_step) begin
            if (i_func == dhtfd_pkg::FUNC_EDGE) begin
                if (in_window) begin
                    r_bit_shift <= {r_bit_shift[dhtfd_pkg::DATA_BITS-2:0], bit_val};
                end
                if (r_edge_count != dhtfd_pkg::COUNT_MAX) begin
                    r_edge_count <= r_edge_count + 1'b1;
                end
            end else begin
                // end of frame rearms the decoder
                r_edge_count <= '0;
                r_bit_shift  <= '0;
                if (frame_full && sum_ok) begin
                    r_held_humidity   <= b0;
                    r_held_temp_whole <= b2;
                    r_held_temp_frac  <= b3;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/dhtfd_checker.sv =====
// dhtfd_checker: port-level assertions for the frame decoder, bound to the top
// depends on dhtfd_pkg and dht_frame_decoder
`default_nettype none

module dhtfd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       i_func,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_status,
    input wire logic [7:0] o_humidity,
    input wire logic       pready
);

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("result or busy input stage after reset");

    // a stalled result beat stays valid and holds its status and humidity
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status) &&
                                           $stable(o_humidity)))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == dhtfd_pkg::ST_GOOD ||
                         o_status == dhtfd_pkg::ST_CHECKSUM ||
                         o_status == dhtfd_pkg::ST_SHORT))
        else $error("undefined status code");

    // an accepted edge beat never holds back the input, whether or not the output slot is free
    a_edge_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_func == dhtfd_pkg::FUNC_EDGE) |=> o_in_ready)
        else $error("input stalled behind an edge beat");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind dht_frame_decoder dhtfd_checker u_dhtfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_func      (i_func),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_humidity  (o_humidity),
    .pready      (pready)
);

`default_nettype wire

// ===== tb/sv/dhtfd_tb_pkg.sv =====
// dhtfd_tb_pkg: expected-reading tracker for the sensor frame decoder bench
// mirrors the decoder state per accepted beat and checks each result beat
// depends on dhtfd_pkg
package dhtfd_tb_pkg;

    class reading_tracker;
        int unsigned                        lead_edges;
        logic [dhtfd_pkg::BYTE_W-1:0]       threshold;
        logic [dhtfd_pkg::COUNT_W-1:0]      edge_count;
        logic [dhtfd_pkg::DATA_BITS-1:0]    bit_shift;
        logic [dhtfd_pkg::BYTE_W-1:0]       held_humidity;
        logic [dhtfd_pkg::BYTE_W-1:0]       held_temp_whole;
        logic [dhtfd_pkg::BYTE_W-1:0]       held_temp_frac;
        dhtfd_pkg::t_result                 expected_readings[$];
        int unsigned                        mismatches;

        function new(int unsigned lead);
            lead_edges      = lead;
            threshold       = dhtfd_pkg::THRESHOLD_RESET;
            edge_count      = '0;
            bit_shift       = '0;
            held_humidity   = '0;
            held_temp_whole = '0;
            held_temp_frac  = '0;
            mismatches      = 0;
        endfunction

        function void set_threshold(logic [dhtfd_pkg::BYTE_W-1:0] value);
            threshold = value;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // one accepted input beat: edges update the frame, end of frame yields a reading
        function void note_beat(logic func, logic [dhtfd_pkg::BYTE_W-1:0] interval);
            dhtfd_pkg::t_result           reading;
            logic [dhtfd_pkg::BYTE_W-1:0] checksum;
            if (func == dhtfd_pkg::FUNC_EDGE) begin
                if (edge_count >= lead_edges && edge_count < lead_edges + dhtfd_pkg::DATA_BITS)
                    bit_shift = {bit_shift[dhtfd_pkg::DATA_BITS-2:0], interval > threshold};
                if (edge_count != dhtfd_pkg::COUNT_MAX)
                    edge_count = edge_count + 1'b1;
            end else begin
                if (edge_count < lead_edges + dhtfd_pkg::DATA_BITS) begin
                    reading.status = dhtfd_pkg::ST_SHORT;
                end else begin
                    checksum = bit_shift[39:32] + bit_shift[31:24] + bit_shift[23:16]
                             + bit_shift[15:8];
                    if (checksum == bit_shift[7:0]) begin
                        held_humidity   = bit_shift[39:32];
                        held_temp_whole = bit_shift[23:16];
                        held_temp_frac  = bit_shift[15:8];
                        reading.status  = dhtfd_pkg::ST_GOOD;
                    end else begin
                        reading.status  = dhtfd_pkg::ST_CHECKSUM;
                    end
                end
                edge_count         = '0;
                bit_shift          = '0;
                reading.humidity   = held_humidity;
                reading.temp_whole = held_temp_whole;
                reading.temp_frac  = held_temp_frac;
                expected_readings.push_back(reading);
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got,
                                    realtime now);
            if (got !== want) begin
                $display("%0.3f ns: %s expected %0d got %0d", now, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reading(dhtfd_pkg::t_result got, realtime now);
            dhtfd_pkg::t_result want;
            if (expected_readings.size() == 0) begin
                $display("%0.3f ns: reading with none expected: hum %0d whole %0d frac %0d st %0d",
                         now, got.humidity, got.temp_whole, got.temp_frac, got.status);
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                compare_field("humidity", want.humidity, got.humidity, now);
                compare_field("temp_whole", want.temp_whole, got.temp_whole, now);
                compare_field("temp_frac", want.temp_frac, got.temp_frac, now);
                compare_field("status", 8'(want.status), 8'(got.status), now);
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/dht_frame_decoder_tb.sv =====
// dht_frame_decoder_tb: drives edge and end-of-frame beats into the decoder,
// sweeps the bit threshold over apb and checks every reading against the tracker
// depends on dhtfd_pkg, dhtfd_tb_pkg and the dht_frame_decoder rtl
module dht_frame_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAD_EDGES    = 2;
    localparam int FRAME_EDGES   = LEAD_EDGES + dhtfd_pkg::DATA_BITS;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_in_valid    = 1'b0;
    logic                             o_in_ready;
    logic                             i_func        = dhtfd_pkg::FUNC_EDGE;
    logic [7:0]                       i_interval_us = '0;
    logic                             o_out_valid;
    logic                             i_out_ready   = 1'b0;
    logic [7:0]                       o_humidity;
    logic [7:0]                       o_temp_whole;
    logic [7:0]                       o_temp_frac;
    logic [1:0]                       o_status;
    logic                             psel          = 1'b0;
    logic                             penable       = 1'b0;
    logic                             pwrite        = 1'b0;
    logic [dhtfd_pkg::CFG_ADDR_W-1:0] paddr         = '0;
    logic [dhtfd_pkg::CFG_DATA_W-1:0] pwdata        = '0;
    logic [dhtfd_pkg::CFG_DATA_W-1:0] prdata;
    logic                             pready;

    dhtfd_tb_pkg::reading_tracker tracker = new(LEAD_EDGES);

    int          send_idle_pct = 24;
    int          recv_idle_pct = 57;
    bit          hold_request  = 1'b0;
    int          quiet_cycles  = 0;
    int          beats_sent    = 0;
    int          frames_sent   = 0;
    logic [7:0]  cur_threshold = dhtfd_pkg::THRESHOLD_RESET;

    dht_frame_decoder #(
        .LEAD_EDGES(LEAD_EDGES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_interval_us(i_interval_us),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_humidity   (o_humidity),
        .o_temp_whole (o_temp_whole),
        .o_temp_frac  (o_temp_frac),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // beat monitor and stall counter
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                tracker.note_beat(i_func, i_interval_us);
            if (o_out_valid && i_out_ready)
                tracker.check_reading(dhtfd_pkg::t_result'({o_humidity, o_temp_whole,
                                                            o_temp_frac, o_status}),
                                      $realtime);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("dht_frame_decoder_tb: errors");
        $finish;
    end

    // result side: random backpressure, plus a long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(input logic func, input logic [7:0] interval);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_interval_us <= interval;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
        if (func == dhtfd_pkg::FUNC_EOF)
            frames_sent++;
    endtask

    // wanted-bit interval, biased to threshold and extremes; a 1 fails at threshold 255
    function automatic logic [7:0] bit_interval(bit one);
        int pick;
        pick = $urandom_range(3);
        if (!one) begin
            if (pick == 0)      return cur_threshold;
            else if (pick == 1) return 8'd0;
            else                return 8'($urandom_range(cur_threshold, 0));
        end
        if (cur_threshold == 8'hFF) return 8'hFF;
        if (pick == 0)      return cur_threshold + 8'd1;
        else if (pick == 1) return 8'hFF;
        else                return 8'($urandom_range(255, cur_threshold + 1));
    endfunction

    function automatic logic [dhtfd_pkg::DATA_BITS-1:0] make_frame(input logic [31:0] data,
                                                                   input bit corrupt);
        logic [7:0] checksum;
        checksum = data[31:24] + data[23:16] + data[15:8] + data[7:0];
        if (corrupt)
            checksum = checksum ^ 8'($urandom_range(255, 1));
        return {data, checksum};
    endfunction

    // total_edges below FRAME_EDGES gives a short frame, above it extra edges
    task automatic send_frame(input logic [dhtfd_pkg::DATA_BITS-1:0] bits,
                              input int total_edges);
        for (int e = 0; e < total_edges; e++) begin
            if (e >= LEAD_EDGES && e < FRAME_EDGES)
                send_beat(dhtfd_pkg::FUNC_EDGE,
                          bit_interval(bits[dhtfd_pkg::DATA_BITS-1-(e-LEAD_EDGES)]));
            else
                send_beat(dhtfd_pkg::FUNC_EDGE, 8'($urandom));
        end
        send_beat(dhtfd_pkg::FUNC_EOF, 8'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dhtfd_pkg::CFG_ADDR_W'(4 * dhtfd_pkg::REG_BIT_THRESHOLD);
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_threshold(value);
        cur_threshold = value;
    endtask

    task automatic run_random_phase(input int min_beats, input int min_frames);
        int first_beat;
        int first_frame;
        int pick;
        first_beat  = beats_sent;
        first_frame = frames_sent;
        while (beats_sent - first_beat < min_beats || frames_sent - first_frame < min_frames) begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_frame(make_frame($urandom, 1'b0), FRAME_EDGES);
            else if (pick < 75)
                send_frame(make_frame($urandom, 1'b1), FRAME_EDGES);
            else if (pick < 85)
                send_frame(make_frame($urandom, 1'b0), $urandom_range(FRAME_EDGES - 1, 0));
            else if (pick < 92)
                send_frame(make_frame($urandom, 1'b0), FRAME_EDGES + $urandom_range(30, 1));
            else
                repeat ($urandom_range(20, 1))
                    send_beat(($urandom_range(99) < 20) ? dhtfd_pkg::FUNC_EOF
                                                        : dhtfd_pkg::FUNC_EDGE,
                              8'($urandom));
        end
        drain();
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at the reset threshold
        send_beat(dhtfd_pkg::FUNC_EOF, 8'hFF);
        send_frame(make_frame(32'h3700_1905, 1'b0), FRAME_EDGES);
        send_frame(make_frame(32'h4102_1C09, 1'b1), FRAME_EDGES);
        send_frame(make_frame(32'h2A00_1600, 1'b0), 30);
        send_frame(make_frame(32'h5100_2003, 1'b0), FRAME_EDGES + 28);
        send_frame(make_frame(32'hFFFF_FFFF, 1'b0), FRAME_EDGES);
        send_frame(make_frame(32'h0000_0000, 1'b0), FRAME_EDGES);
        send_frame(make_frame(32'h1234_5678, 1'b0), FRAME_EDGES - 1);
        drain();

        write_threshold(8'd0);
        run_random_phase(190, 4);
        write_threshold(8'd255);
        run_random_phase(190, 4);

        send_idle_pct = 57;
        recv_idle_pct = 24;
        write_threshold(8'($urandom));
        run_random_phase(190, 4);
        write_threshold(8'd1);
        run_random_phase(190, 4);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(8'd254);
        hold_request = 1'b1;
        run_random_phase(190, 4);
        write_threshold(8'($urandom));
        run_random_phase(190, 4);

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("dht_frame_decoder_tb: clean");
        end else begin
            $display("dht_frame_decoder_tb: errors");
        end
        $finish;
    end

endmodule
